>>> rtl/stalta_pkg.sv
// Shared types, constants and control bundles for the STA/LTA event detector.
package stalta_pkg;

  // Sample and window geometry
  localparam int SampleBits  = 16;
  localparam int ShortWindow = 2;
  localparam int LongWindow  = 5;
  localparam int FracBits    = 12;
  localparam int QuotBits    = 14;  // integer part (ratio <= 2.5) plus fraction
  localparam int CountBits   = 24;
  localparam int TimeBits    = 48;
  localparam int SqBits      = 31;  // largest square is 2**30
  localparam int ShortBits   = 32;
  localparam int LongBits    = 33;
  localparam int RemBits     = 36;  // shifted remainder stays below 4 * long_sum * 2
  localparam int DivBits     = 35;  // 4 * long_sum
  localparam int StepBits    = 4;
  localparam int SelBits     = 3;

  localparam logic [CountBits-1:0] CountMax = '1;

  // Configuration register indexes
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 24;
  localparam logic [CfgIdxBits-1:0] RegThreshold = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegTimeStep  = 1'b1;

  localparam logic [15:0] ThresholdReset = 16'd8192;
  localparam logic [23:0] TimeStepReset  = 24'd1;

  // Input request
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         record_start;
  } sta_in_t;

  // Result
  typedef struct packed {
    logic [CountBits-1:0] sample_index;
    logic [TimeBits-1:0]  event_time;
    logic [ShortBits-1:0] short_sum;
    logic [LongBits-1:0]  long_sum;
    logic [QuotBits-1:0]  power_ratio;
    logic                 event_flag;
    logic                 zero_power;
  } sta_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               load;       // take a sample, shift window, update count
    logic               sq_en;      // square the selected window entry
    logic [SelBits-1:0] sq_sel;
    logic               acc_en;     // add last square to the long sum
    logic               acc_short;  // ... and to the short sum
    logic               div_init;
    logic               div_step;
    logic               out_load;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic has_result;  // accepted sample completes a full long window
    logic zero_power;  // long sum is zero
  } dp_status_t;

endpackage

>>> rtl/sta_lta_event_detector_core.sv
// Top level of the STA/LTA event detector: controller plus datapath.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) takes one signed sample
//   and a record_start mark per request. Result channel (out_valid_o /
//   out_ready_i / out_rsp_o) returns one result per sample from the fifth
//   sample of a record on; earlier samples only fill the window.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 threshold, 1 time step) at once; write only while the block is idle.
// Timing:
//   A sample without a result leaves the block idle, ready for the next sample.
//   A sample with a result is accepted, then the five window entries are squared
//   through one shared multiplier, the divider is set up, the bit-serial ratio
//   divider runs and the output register is loaded, which raises out_valid_o.
//   With zero long power the divider is skipped.
//   in_ready_o returns high the cycle after the result is loaded.
// Reset clears the sample count, state machine and output valid, and loads
// threshold 8192 and time step 1. A stalled receiver holds the result in the
// output register; the block accepts the next sample meanwhile and waits for
// the register to free before loading the next result.
module sta_lta_event_detector_core import stalta_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sta_in_t                in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sta_out_t               out_rsp_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  stalta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stalta_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

>>> rtl/stalta_dp.sv
// Datapath: sample window, square/accumulate unit, restoring divider, output register.
module stalta_dp import stalta_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  sta_in_t                in_req_i,
  input  ctl_cmd_t               cmd_i,
  output dp_status_t             status_o,
  output sta_out_t               out_rsp_o
);

  logic [15:0]                 thr_q;
  logic [23:0]                 tstep_q;
  logic [SampleBits-1:0]       win_q [LongWindow];
  logic [CountBits-1:0]        count_q, count_d;
  logic [CountBits-1:0]        idx_q, idx_d;
  logic [SqBits-1:0]           sq_q;
  logic [ShortBits-1:0]        short_q;
  logic [LongBits-1:0]         long_q;
  logic [RemBits-1:0]          rem_q;
  logic [DivBits-1:0]          dd_q;
  logic [QuotBits-1:0]         quot_q;
  logic [TimeBits-1:0]         etime_q;
  sta_out_t                    out_q;

  logic [SampleBits-1:0]       sq_in;
  logic [SampleBits:0]         sq_ext;
  logic [SampleBits:0]         sq_mag;
  logic [2*SampleBits+1:0]     sq_full;
  logic [RemBits:0]            div_diff;
  logic                        div_ge;
  logic                        zero_pw;
  logic                        ev;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThresholdReset;
      tstep_q <= TimeStepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThreshold: thr_q   <= cfg_data_i[15:0];
        RegTimeStep:  tstep_q <= cfg_data_i[23:0];
        default:      thr_q   <= thr_q;
      endcase
    end
  end

  // Record position: record_start restarts the count before this sample
  always_comb begin
    idx_d   = in_req_i.record_start ? '0 : count_q;
    count_d = (idx_d < CountMax) ? idx_d + 1'b1 : idx_d;
  end

  assign zero_pw  = (long_q == '0);
  assign status_o = '{has_result: (idx_d >= CountBits'(LongWindow - 1)),
                      zero_power: zero_pw};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_d;
    end
  end

  // Sample window, newest at entry 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q[0] <= in_req_i.sample;
      for (int i = 1; i < LongWindow; i++) begin
        win_q[i] <= win_q[i-1];
      end
      idx_q <= idx_d;
    end
  end

  // Magnitude square of one window entry per cycle
  always_comb begin
    sq_in   = (cmd_i.sq_sel < SelBits'(LongWindow)) ? win_q[cmd_i.sq_sel] : '0;
    sq_ext  = {sq_in[SampleBits-1], sq_in};
    sq_mag  = sq_in[SampleBits-1] ? (~sq_ext + 1'b1) : sq_ext;
    sq_full = sq_mag * sq_mag;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q <= sq_full[SqBits-1:0];
    end
  end

  // Window sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      short_q <= '0;
      long_q  <= '0;
    end else if (cmd_i.acc_en) begin
      long_q <= long_q + LongBits'(sq_q);
      if (cmd_i.acc_short) begin
        short_q <= short_q + ShortBits'(sq_q);
      end
    end
  end

  // Restoring divider: (5 * short) / (2 * long), one quotient bit a cycle.
  // Divisor is doubled so the first step yields the integer bit of weight 2.
  always_comb begin
    div_diff = {1'b0, rem_q} - (RemBits+1)'(dd_q);
    div_ge   = !div_diff[RemBits];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q   <= RemBits'({short_q, 2'b00}) + RemBits'(short_q);
      dd_q    <= {long_q, 2'b00};
      quot_q  <= '0;
      etime_q <= TimeBits'(idx_q) * TimeBits'(tstep_q);
    end else if (cmd_i.div_step) begin
      rem_q  <= {(div_ge ? div_diff[RemBits-2:0] : rem_q[RemBits-2:0]), 1'b0};
      quot_q <= {quot_q[QuotBits-2:0], div_ge};
    end
  end

  // Exact threshold test: ratio above threshold, or equal with a remainder left
  assign ev = !zero_pw &&
              ((16'(quot_q) > thr_q) || ((16'(quot_q) == thr_q) && (rem_q != '0)));

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.sample_index <= idx_q;
      out_q.event_time   <= etime_q;
      out_q.short_sum    <= short_q;
      out_q.long_sum     <= long_q;
      out_q.power_ratio  <= zero_pw ? '0 : quot_q;
      out_q.event_flag   <= ev;
      out_q.zero_power   <= zero_pw;
    end
  end

  assign out_rsp_o = out_q;

  // The remainder never reaches twice the divisor while dividing
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> ({1'b0, rem_q} < {dd_q, 1'b0}))
    else $error("divider remainder out of range");

  // The short window sum never exceeds the long window sum
  a_short_le_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (LongBits'(short_q) <= long_q))
    else $error("short sum exceeds long sum");

endmodule

>>> rtl/stalta_ctrl.sv
// Controller: sequences load, square/accumulate, divide and result hand-off.
module stalta_ctrl import stalta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_SETUP  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [StepBits-1:0] step_q, step_d;
  logic                out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          if (status_i.has_result) state_d = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd_o.sq_en     = (step_q < StepBits'(LongWindow));
        cmd_o.sq_sel    = step_q[SelBits-1:0];
        cmd_o.acc_en    = (step_q != '0);
        cmd_o.acc_short = (step_q <= StepBits'(ShortWindow));
        step_d          = step_q + 1'b1;
        if (step_q == StepBits'(LongWindow)) state_d = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = status_i.zero_power ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == StepBits'(QuotBits - 1)) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the result request is taken
  always_comb begin
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // A sample that completes no window leaves the block idle
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !status_i.has_result) |=> (state_q == S_IDLE))
    else $error("work started for a sample without result");

  // The divider runs exactly one step per quotient bit
  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q < StepBits'(QuotBits)))
    else $error("divider step count overrun");

endmodule
